// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, operation codes, character codes and the command and status
// bundles exchanged between the console controller and its datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // Address source for the cell memory.
    localparam logic [1:0] ASEL_CURSOR = 2'd0;
    localparam logic [1:0] ASEL_READ   = 2'd1;
    localparam logic [1:0] ASEL_SCROLL = 2'd2;
    localparam logic [1:0] ASEL_FLAT   = 2'd3;

    // Write data source for the cell memory.
    localparam logic [1:0] WSEL_SPACE = 2'd0;
    localparam logic [1:0] WSEL_ZERO  = 2'd1;
    localparam logic [1:0] WSEL_CHAR  = 2'd2;

    typedef struct packed {
        logic       take;
        logic       we;
        logic [1:0] asel;
        logic [1:0] wsel;
        logic       sweep_inc;
        logic       sweep_clr;
        logic       cur_adv;
        logic       scroll_done;
        logic       home;
        logic       rd_capture;
        logic       load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic       is_tab;
        logic       is_newline;
        logic       row_past;
        logic       tab_as_newline;
        logic       phase_last;
        logic       col_last;
        logic       sweep_row_last;
        logic       sweep_all_last;
        logic       read_in_range;
    } tcw_status_t;

endpackage

// ----- rtl/core/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell console: prints characters with tab, newline, wrap and
// scroll handling, reads back cells and clears the screen.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                     Carries
//  s_axis    in         s_tvalid/s_tready/s_tdata   ch, cell_row, cell_col
//                       s_tuser                     func
//  m_axis    out        m_tvalid/m_tready/m_tdata   read_char, cursor_row,
//                                                   cursor_col
//
// An ordinary printed character is written to its cell and the cursor is then
// advanced; a read fetches the cell, or gives zero when the cell lies off the
// screen, and an unused operation code goes straight to the result. A tab or a
// newline writes its cells one after another, and a clear writes every cell.
// Every scroll zero-fills one row. All of this is set by the single port of the
// cell memory, which takes one access per cycle. s_tready is high again in the
// cycle in which the result appears on m_tvalid.
// After reset the block sweeps the whole cell memory with spaces while
// s_tready is held low.
// One operation is in progress at a time. The next transaction is accepted
// while the previous result still waits in the output register; a stalled
// output holds the block only when the next result is ready to load.
//
// Scrolling does not move the stored rows. A row origin register rotates the
// logical rows onto the physical rows, so a scroll only zero-fills the old
// top row and advances the origin.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80,
    parameter int TAB_STOP    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ch[7:0], cell_row[12:8], cell_col[19:13], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_char[7:0], cursor_row[12:8], cursor_col[19:13]
);
    import tcw_pkg::*;

    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;

    // Sequencer: decides what the datapath does in each cycle.
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: cursor, row origin, cell memory and the result register.
    tcw_datapath #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .TAB_STOP    (TAB_STOP)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_ch      (s_tdata[7:0]),
        .in_row     (s_tdata[12:8]),
        .in_col     (s_tdata[19:13]),
        .read_char  (read_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

    // The upper four bits of the result word are always zero.
    assign m_tdata = {4'b0000, cursor_col, cursor_row, read_char};

endmodule

// ----- rtl/core/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, scroll origin, sweep counter, cell memory and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80,
    parameter int TAB_STOP    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::tcw_cmd_t           cmd,
    output tcw_pkg::tcw_status_t        status,
    input  logic [tcw_pkg::CHAR_W-1:0]  in_ch,
    input  logic [tcw_pkg::ROW_W-1:0]   in_row,
    input  logic [tcw_pkg::COL_W-1:0]   in_col,
    output logic [tcw_pkg::CHAR_W-1:0]  read_char,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   cursor_col
);
    import tcw_pkg::*;

    localparam int CELLS   = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PHASE_W = $clog2(TAB_STOP);

    logic [CHAR_W-1:0]  ch_reg;
    logic [ROW_W-1:0]   rrow_reg;
    logic [COL_W-1:0]   rcol_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic [CHAR_W-1:0]  rd_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;

    logic [ROW_W-1:0]   lrow;
    logic [COL_W-1:0]   lcol;
    logic [ROW_W:0]     row_sum;
    logic [ROW_W-1:0]   prow;
    logic [ADDR_W-1:0]  addr;
    logic [CHAR_W-1:0]  wdata;
    logic [CHAR_W-1:0]  rdata;

    // Logical row and column of the access, then the rotated physical row.
    always_comb
    begin
        case (cmd.asel)
            ASEL_CURSOR:
            begin
                lrow = row_reg;
                lcol = col_reg;
            end
            ASEL_READ:
            begin
                lrow = rrow_reg;
                lcol = rcol_reg;
            end
            default:
            begin
                lrow = '0;
                lcol = COL_W'(sweep_reg);
            end
        endcase
        row_sum = {1'b0, lrow} + {1'b0, top_reg};
        if (row_sum >= (ROW_W + 1)'(SCREEN_ROWS))
        begin
            prow = ROW_W'(row_sum - (ROW_W + 1)'(SCREEN_ROWS));
        end
        else
        begin
            prow = ROW_W'(row_sum);
        end
        if (cmd.asel == ASEL_FLAT)
        begin
            addr = sweep_reg;
        end
        else
        begin
            addr = ADDR_W'(ADDR_W'(prow) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(lcol);
        end
        case (cmd.wsel)
            WSEL_SPACE: wdata = CHAR_SPACE;
            WSEL_CHAR:  wdata = ch_reg;
            default:    wdata = CHAR_ZERO;
        endcase
    end

    tcw_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cells (
        .clk   (clk),
        .we    (cmd.we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Cursor, origin and sweep updates.
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        top_next   = top_reg;
        sweep_next = sweep_reg;
        if (cmd.cur_adv)
        begin
            if (col_reg == COL_W'(SCREEN_COLS - 1))
            begin
                col_next   = '0;
                phase_next = '0;
                row_next   = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (phase_reg == PHASE_W'(TAB_STOP - 1))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
        if (cmd.scroll_done)
        begin
            row_next = row_reg - 1'b1;
            if (top_reg == ROW_W'(SCREEN_ROWS - 1))
            begin
                top_next = '0;
            end
            else
            begin
                top_next = top_reg + 1'b1;
            end
        end
        if (cmd.home)
        begin
            row_next   = '0;
            col_next   = '0;
            phase_next = '0;
            top_next   = '0;
        end
        if (cmd.sweep_clr)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_inc)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            top_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            top_reg   <= top_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ch_reg   <= in_ch;
            rrow_reg <= in_row;
            rcol_reg <= in_col;
            rd_reg   <= CHAR_ZERO;
        end
        else if (cmd.rd_capture)
        begin
            rd_reg <= rdata;
        end
        if (cmd.load_out)
        begin
            out_char_reg <= rd_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
        end
    end

    assign read_char  = out_char_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

    assign status.is_tab         = (ch_reg == CHAR_TAB);
    assign status.is_newline     = (ch_reg == CHAR_NEWLINE);
    assign status.row_past       = (row_reg >= ROW_W'(SCREEN_ROWS));
    assign status.tab_as_newline = (col_reg >= COL_W'(SCREEN_COLS - TAB_STOP));
    assign status.phase_last     = (phase_reg == PHASE_W'(TAB_STOP - 1));
    assign status.col_last       = (col_reg == COL_W'(SCREEN_COLS - 1));
    assign status.sweep_row_last = (sweep_reg == ADDR_W'(SCREEN_COLS - 1));
    assign status.sweep_all_last = (sweep_reg == ADDR_W'(CELLS - 1));
    assign status.read_in_range  = (rrow_reg < ROW_W'(SCREEN_ROWS)) &&
                                   (rcol_reg < COL_W'(SCREEN_COLS));

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: runs prints, scrolls, fills, reads and clears, and
// owns the input ready and the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [tcw_pkg::FUNC_W-1:0]    in_func,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  tcw_pkg::tcw_status_t          status,
    output tcw_pkg::tcw_cmd_t             cmd
);
    import tcw_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SETTLE = 4'd2;
    localparam logic [3:0] S_SCROLL = 4'd3;
    localparam logic [3:0] S_CHAR   = 4'd4;
    localparam logic [3:0] S_TAB    = 4'd5;
    localparam logic [3:0] S_NL     = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_RDWAIT = 4'd8;
    localparam logic [3:0] S_CLEAR  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       post_reg, post_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        post_next  = post_reg;
        cmd        = '0;
        cmd.asel   = ASEL_CURSOR;
        cmd.wsel   = WSEL_SPACE;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cmd.we        = 1'b1;
                cmd.asel      = ASEL_FLAT;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_all_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    cmd.home      = 1'b1;
                    state_next    = (state_reg == S_INIT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take  = 1'b1;
                    post_next = 1'b0;
                    case (in_func)
                        FUNC_PRINT: state_next = S_SETTLE;
                        FUNC_READ:  state_next = S_READ;
                        FUNC_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_EMIT;
                    endcase
                end
            end
            S_SETTLE:
            begin
                if (status.row_past)
                begin
                    state_next = S_SCROLL;
                end
                else if (post_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (status.is_tab && !status.tab_as_newline)
                begin
                    state_next = S_TAB;
                end
                else if (status.is_tab || status.is_newline)
                begin
                    state_next = S_NL;
                end
                else
                begin
                    state_next = S_CHAR;
                end
            end
            S_SCROLL:
            begin
                // The old top row becomes the new bottom row, zero filled.
                cmd.we        = 1'b1;
                cmd.asel      = ASEL_SCROLL;
                cmd.wsel      = WSEL_ZERO;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_row_last)
                begin
                    cmd.sweep_clr   = 1'b1;
                    cmd.scroll_done = 1'b1;
                    state_next      = S_SETTLE;
                end
            end
            S_CHAR:
            begin
                cmd.we      = 1'b1;
                cmd.wsel    = WSEL_CHAR;
                cmd.cur_adv = 1'b1;
                post_next   = 1'b1;
                state_next  = S_SETTLE;
            end
            S_TAB:
            begin
                cmd.we      = 1'b1;
                cmd.cur_adv = 1'b1;
                if (status.phase_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_NL:
            begin
                cmd.we      = 1'b1;
                cmd.cur_adv = 1'b1;
                if (status.col_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                cmd.asel   = ASEL_READ;
                state_next = status.read_in_range ? S_RDWAIT : S_EMIT;
            end
            S_RDWAIT:
            begin
                cmd.asel       = ASEL_READ;
                cmd.rd_capture = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            post_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_writer_core. A behavioral mirror of the
// screen and cursor predicts every result; directed tests cover the power-on
// screen, the operation codes, the line edges and the bottom row, then a long
// randomized run of text lines, cell reads, random noise operations and
// clears follows. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int TAB_W = 8;
    localparam int CELLS = ROWS * COLS;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int MAX_GAP       = 8;
    localparam int RANDOM_ITEMS  = 930;
    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int REPORT_LIMIT  = 10;

    // Packed so that the cursor column lands in the top bits, matching m_tdata.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] read_char;
    } console_status_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Mirror of the screen contents and the cursor.
    logic [CHAR_W-1:0] screen_mirror [CELLS];
    int                cursor_row_m;
    int                cursor_col_m;

    console_status_t expected_status [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int sink_hold    = 0;
    int quiet_cycles = 0;
    bit took_result  = 1'b0;
    bit source_gaps  = 1'b1;
    bit sink_stalls  = 1'b1;

    always #1 clk = ~clk;

    text_console_writer_core #(
        .SCREEN_ROWS (ROWS),
        .SCREEN_COLS (COLS),
        .TAB_STOP    (TAB_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Screen mirror
    // ------------------------------------------------------------------------
    function automatic void mirror_put(int r, int c, logic [CHAR_W-1:0] v);
        if (r < ROWS && c < COLS)
            screen_mirror[r * COLS + c] = v;
    endfunction

    function automatic logic [CHAR_W-1:0] mirror_get(int r, int c);
        if (r < ROWS && c < COLS)
            return screen_mirror[r * COLS + c];
        return CHAR_ZERO;
    endfunction

    function automatic void mirror_clear();
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = CHAR_SPACE;
        cursor_row_m = 0;
        cursor_col_m = 0;
    endfunction

    // Scroll up one line for as long as the cursor sits below the last row.
    // The row that comes in at the bottom is filled with zero bytes.
    function automatic void mirror_settle();
        while (cursor_row_m >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_mirror[i] = screen_mirror[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_mirror[i] = CHAR_ZERO;
            if (cursor_row_m > 0)
                cursor_row_m--;
        end
    endfunction

    function automatic void mirror_print(logic [CHAR_W-1:0] c);
        mirror_settle();
        if (c == CHAR_TAB && cursor_col_m < COLS - TAB_W)
        begin
            do
            begin
                mirror_put(cursor_row_m, cursor_col_m, CHAR_SPACE);
                cursor_col_m++;
            end while ((cursor_col_m % TAB_W) != 0 && cursor_col_m < COLS);
            return;
        end
        // A tab close to the right edge behaves exactly like a newline.
        if (c == CHAR_TAB || c == CHAR_NEWLINE)
        begin
            while (cursor_col_m < COLS)
            begin
                mirror_put(cursor_row_m, cursor_col_m, CHAR_SPACE);
                cursor_col_m++;
            end
            cursor_row_m = (cursor_row_m + 1) & 31;
            cursor_col_m = 0;
            return;
        end
        mirror_put(cursor_row_m, cursor_col_m, c);
        cursor_col_m++;
        if (cursor_col_m >= COLS)
        begin
            cursor_row_m = (cursor_row_m + 1) & 31;
            cursor_col_m = 0;
        end
        mirror_settle();
    endfunction

    function automatic console_status_t predict_status(logic [FUNC_W-1:0] op,
                                                       logic [CHAR_W-1:0] ch,
                                                       logic [ROW_W-1:0]  row,
                                                       logic [COL_W-1:0]  col);
        console_status_t s;
        s.read_char = CHAR_ZERO;
        case (op)
            FUNC_PRINT: mirror_print(ch);
            FUNC_READ:  s.read_char = mirror_get(row, col);
            FUNC_CLEAR: mirror_clear();
            default:    ;
        endcase
        s.row = cursor_row_m[ROW_W-1:0];
        s.col = cursor_col_m[COL_W-1:0];
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly printable text, with some raw bytes, newlines and tabs mixed in.
    function automatic logic [CHAR_W-1:0] text_char();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return CHAR_W'($urandom_range(8'h20, 8'h7E));
        if (k < 80)
            return CHAR_W'($urandom_range(0, 255));
        if (k < 90)
            return CHAR_NEWLINE;
        return CHAR_TAB;
    endfunction

    function automatic logic [CHAR_W-1:0] printable_char();
        return CHAR_W'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Sends one transaction and records the result it must produce. Called
    // just after a falling edge and returns just after a falling edge.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int gap;
        gap = source_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, col, row, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_status.push_back(predict_status(op, ch, row, col));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic print_char(input logic [CHAR_W-1:0] ch);
        send_op(FUNC_PRINT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input int row, input int col);
        send_op(FUNC_READ, CHAR_W'($urandom), ROW_W'(row), COL_W'(col));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_power_on_screen();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(0, COLS - 1);
        read_cell(ROWS - 1, 0);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(31, 127);
    endtask

    task automatic test_operation_codes();
        print_char(CHAR_ZERO);
        print_char(8'hFF);
        print_char(printable_char());
        print_char(CHAR_TAB);
        print_char(CHAR_NEWLINE);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(0, 5);
        read_cell(1, 0);
        send_op(FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
        send_op(FUNC_UNUSED, 8'h00, 5'h00, 7'h00);
        send_op(FUNC_CLEAR, 8'hFF, 5'h1F, 7'h7F);
        read_cell(0, 0);
    endtask

    // Tab near the right edge, a tab that writes a single space, and a line
    // filled exactly to the wrap point.
    task automatic test_line_edges();
        int stop_col;
        print_char(CHAR_NEWLINE);
        stop_col = COLS - TAB_W + $urandom_range(0, TAB_W - 1);
        while (cursor_col_m < stop_col)
            print_char(printable_char());
        print_char(CHAR_TAB);
        while (cursor_col_m < COLS - TAB_W - 1)
            print_char(printable_char());
        print_char(CHAR_TAB);
        while (cursor_col_m != 0)
            print_char(printable_char());
        for (int c = COLS - TAB_W - 2; c < COLS; c++)
            read_cell(cursor_row_m - 1, c);
    endtask

    // Newline on the last row leaves the cursor one row past the screen; the
    // next print scrolls first. A full last row wraps and scrolls at once.
    task automatic test_bottom_row();
        while (cursor_row_m < ROWS - 1)
        begin
            if ($urandom_range(0, 1))
                print_char(printable_char());
            print_char(CHAR_NEWLINE);
        end
        print_char(printable_char());
        print_char(printable_char());
        print_char(CHAR_NEWLINE);
        send_op(FUNC_UNUSED, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 1, 1);
        read_cell(ROWS - 1, COLS - 1);
        print_char(printable_char());
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 1, 1);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS - 2, 0);
        // The cursor stays on the last row, so the wrap shows as column zero.
        while (cursor_col_m != 0)
            print_char(text_char() == CHAR_NEWLINE ? CHAR_ZERO : printable_char());
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 2, COLS - 1);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int kind;
        int len;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = $urandom_range(1, 90);
                repeat (len)
                    print_char(text_char());
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                        read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                    else
                        read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
                end
            end
            else if (kind < 96)
            begin
                // Noise: any operation but clear, with every field random.
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_op(FUNC_PRINT, CHAR_W'($urandom), ROW_W'($urandom),
                                         COL_W'($urandom));
                        1:       send_op(FUNC_READ, CHAR_W'($urandom), ROW_W'($urandom),
                                         COL_W'($urandom));
                        default: send_op(FUNC_UNUSED, CHAR_W'($urandom), ROW_W'($urandom),
                                         COL_W'($urandom));
                    endcase
                end
            end
            else
            begin
                send_op(FUNC_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, checking against the oldest expectation
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (took_result)
            sink_hold = sink_stalls ? $urandom_range(0, MAX_GAP) : 0;
        if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        console_status_t got;
        console_status_t want;
        took_result = rst_n && m_tvalid && m_tready;
        if (took_result)
        begin
            got = m_tdata[19:0];
            if (expected_status.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected transaction: char %02h row %0d col %0d",
                             got.read_char, got.row, got.col);
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.read_char !== want.read_char || got.row !== want.row ||
                    got.col !== want.col)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"mismatch: expected char %02h row %0d col %0d, ",
                                  "got char %02h row %0d col %0d"},
                                 want.read_char, want.row, want.col,
                                 got.read_char, got.row, got.col);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        mirror_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_screen();
        test_operation_codes();
        test_line_edges();
        test_bottom_row();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer_core.sv
test/tb_top.sv
